// ===== hdl/jkv_pkg.sv =====
// jkv_pkg: shared types and constants for the key/value extractor.
// Used by jkv_resq and json_key_value_extractor; depends on nothing.
package jkv_pkg;

  localparam int KeyCharsDefault = 8;
  localparam int QueueDepth      = 4;

  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChRBrack  = 8'h5D;

  localparam logic [1:0] StByte     = 2'd0;
  localparam logic [1:0] StComplete = 2'd1;
  localparam logic [1:0] StAbsent   = 2'd2;
  localparam logic [1:0] StBeyond   = 2'd3;

  localparam logic [1:0] RegKeyText  = 2'd0;
  localparam logic [1:0] RegKeyLen   = 2'd1;
  localparam logic [1:0] RegIdxMode  = 2'd2;
  localparam logic [1:0] RegElemIdx  = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t [1:0] items;
  } push_t;

endpackage

// ===== hdl/jkv_resq.sv =====
// jkv_resq: small result queue, takes up to two items a cycle, gives one
// unless out_stall is high. Depends on jkv_pkg.
module jkv_resq import jkv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  nearly_full,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_item
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  res_t            mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            pop;

  assign out_valid   = (count_r != '0);
  assign out_item    = mem[rd_ptr_r];
  assign pop         = out_valid && !out_stall;
  assign nearly_full = (count_r > CntW'(QueueDepth - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.items[0];
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_r + PtrW'(1)] <= push.items[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(push.count);
      rd_ptr_r <= rd_ptr_r + PtrW'(pop);
      count_r  <= count_r + CntW'(push.count) - CntW'(pop);
    end
  end

endmodule

// ===== hdl/json_key_value_extractor.sv =====
// json_key_value_extractor: finds "key": in a byte stream and streams its value.
// Depends on jkv_pkg and jkv_resq.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_byte, in_end_of_message
//   out_    | output    | out_valid/out_stall| out_byte, out_status, out_last_result
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; its zero, one or two
// results enter a four-entry queue in the same edge and leave it one per cycle
// while out_stall is low. in_stall rises while the queue holds over two results.
// cfg_ready is always high. Reset is synchronous on rst_n and resets the
// registers (key length to one), the parser state and the queue.
module json_key_value_extractor import jkv_pkg::*; #(
  parameter int KEY_CHARS = KeyCharsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [1:0] {PH_SEARCH, PH_OPEN, PH_VALUE, PH_DONE} phase_t;
  typedef enum logic [1:0] {TK_COMMA, TK_QUOTE, TK_BRACE, TK_BRACKET} term_t;

  localparam logic [3:0] KeyMax = 4'(KEY_CHARS);

  logic [63:0] key_text_r;
  logic [3:0]  key_length_r;
  logic        index_mode_r;
  logic [7:0]  element_index_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  mp_r, mp_nxt;
  term_t       tk_r, tk_nxt;
  logic [7:0]  cc_r, cc_nxt;
  logic        es_r, es_nxt;
  logic        eq_r, eq_nxt;
  logic [7:0]  hb_r, hb_nxt;
  logic        hv_r, hv_nxt;

  logic        accept;
  logic [3:0]  klen, mp_cur, pat_idx;
  logic [7:0]  pat_char, term_char, key_first;
  logic        byte_emit, fin, absent;
  logic [7:0]  byte_val;
  logic [1:0]  fin_st;
  term_t       tk_use;
  logic        run_value;
  push_t       push;
  res_t        head;
  logic        q_nearly_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_nearly_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_text_r      <= '0;
      key_length_r    <= 4'd1;
      index_mode_r    <= 1'b0;
      element_index_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegKeyText: key_text_r      <= cfg_data;
        RegKeyLen:  key_length_r    <= cfg_data[3:0];
        RegIdxMode: index_mode_r    <= cfg_data[0];
        RegElemIdx: element_index_r <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    klen = key_length_r;
    if (klen == 4'd0) klen = 4'd1;
    if (klen > KeyMax) klen = KeyMax;
    mp_cur  = (mp_r > klen + 4'd2) ? 4'd0 : mp_r;
    pat_idx = mp_cur - 4'd1;
    key_first = key_text_r[7:0];
    if (mp_cur == 4'd0) begin
      pat_char = ChQuote;
    end else if (mp_cur <= klen) begin
      pat_char = key_text_r[{pat_idx[2:0], 3'b000} +: 8];
    end else if (mp_cur == klen + 4'd1) begin
      pat_char = ChQuote;
    end else begin
      pat_char = ChColon;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    mp_nxt    = mp_r;
    tk_nxt    = tk_r;
    cc_nxt    = cc_r;
    es_nxt    = es_r;
    eq_nxt    = eq_r;
    hb_nxt    = hb_r;
    hv_nxt    = hv_r;
    byte_emit = 1'b0;
    byte_val  = in_byte;
    fin       = 1'b0;
    absent    = 1'b0;
    run_value = 1'b0;
    tk_use    = tk_r;
    fin_st    = StComplete;
    term_char = ChComma;

    unique case (phase_r)
      PH_SEARCH: begin
        if (in_byte == pat_char) begin
          if (mp_cur + 4'd1 == klen + 4'd3) begin
            mp_nxt    = 4'd0;
            phase_nxt = PH_OPEN;
          end else begin
            mp_nxt = mp_cur + 4'd1;
          end
        end else if (mp_cur == klen + 4'd2 && in_byte == key_first) begin
          mp_nxt = 4'd2;
        end else if (in_byte == ChQuote) begin
          mp_nxt = 4'd1;
        end else begin
          mp_nxt = 4'd0;
        end
      end
      PH_OPEN: begin
        phase_nxt = PH_VALUE;
        if (in_byte == ChQuote) begin
          tk_nxt = TK_QUOTE;
        end else if (in_byte == ChLBrace) begin
          tk_nxt = TK_BRACE;
        end else if (in_byte == ChLBrack) begin
          tk_nxt = TK_BRACKET;
        end else begin
          tk_nxt    = TK_COMMA;
          tk_use    = TK_COMMA;
          run_value = 1'b1;
        end
      end
      PH_VALUE: run_value = 1'b1;
      PH_DONE:  ;
      default:  ;
    endcase

    unique case (tk_use)
      TK_COMMA:   term_char = ChComma;
      TK_QUOTE:   term_char = ChQuote;
      TK_BRACE:   term_char = ChRBrace;
      TK_BRACKET: term_char = ChRBrack;
      default:    term_char = ChComma;
    endcase

    if (run_value) begin
      if (in_byte == term_char) begin
        fin       = 1'b1;
        phase_nxt = PH_DONE;
      end else if (!index_mode_r) begin
        byte_emit = 1'b1;
      end else if (in_byte == ChComma) begin
        if (cc_r >= element_index_r) begin
          fin       = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          cc_nxt = cc_r + 8'd1;
          es_nxt = 1'b1;
          eq_nxt = 1'b0;
          hv_nxt = 1'b0;
        end
      end else if (cc_r == element_index_r) begin
        es_nxt = 1'b0;
        if (es_r && in_byte == ChQuote) begin
          eq_nxt = 1'b1;
        end else if (eq_r) begin
          byte_emit = hv_r;
          byte_val  = hb_r;
          hb_nxt    = in_byte;
          hv_nxt    = 1'b1;
        end else begin
          byte_emit = 1'b1;
        end
      end else begin
        es_nxt = 1'b0;
      end
    end

    if (in_end_of_message) begin
      if (phase_nxt == PH_SEARCH) begin
        fin    = 1'b1;
        absent = 1'b1;
      end else if (phase_nxt == PH_OPEN || phase_nxt == PH_VALUE) begin
        fin = 1'b1;
      end
    end

    if (absent) begin
      fin_st = StAbsent;
    end else if (index_mode_r && cc_nxt < element_index_r) begin
      fin_st = StBeyond;
    end else begin
      fin_st = StComplete;
    end

    if (in_end_of_message) begin
      phase_nxt = PH_SEARCH;
      mp_nxt    = 4'd0;
      tk_nxt    = TK_COMMA;
      cc_nxt    = 8'd0;
      es_nxt    = 1'b1;
      eq_nxt    = 1'b0;
      hb_nxt    = 8'd0;
      hv_nxt    = 1'b0;
    end
  end

  always_comb begin
    push.items[0] = '{data: byte_val, status: StByte, last: 1'b0};
    push.items[1] = '{data: 8'd0, status: fin_st, last: 1'b1};
    if (!byte_emit) begin
      push.items[0] = '{data: 8'd0, status: fin_st, last: 1'b1};
    end
    if (!accept) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'(byte_emit) + 2'(fin);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      mp_r    <= '0;
      tk_r    <= TK_COMMA;
      cc_r    <= '0;
      es_r    <= 1'b1;
      eq_r    <= 1'b0;
      hb_r    <= '0;
      hv_r    <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      mp_r    <= mp_nxt;
      tk_r    <= tk_nxt;
      cc_r    <= cc_nxt;
      es_r    <= es_nxt;
      eq_r    <= eq_nxt;
      hb_r    <= hb_nxt;
      hv_r    <= hv_nxt;
    end
  end

  jkv_resq u_resq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .nearly_full (q_nearly_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (head)
  );

  assign out_byte        = head.data;
  assign out_status      = head.status;
  assign out_last_result = head.last;

endmodule
